// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg - shared definitions for the keyed registration table
// Table geometry, operation codes and status codes.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W       = 32;
  localparam int HDL_W       = 16;
  localparam int ENTRY_W     = KEY_W + HDL_W;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_CNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

// ===== rtl/krt_if.sv =====
// ----------------------------------------------------------------------------
// krt_if - valid/ready channels of the keyed registration table
// Request channel (operation, key, handle) and response channel.
// ----------------------------------------------------------------------------
interface krt_in_if;
  logic                      valid;
  logic                      ready;
  logic [krt_pkg::OP_W-1:0]  opcode;
  logic [krt_pkg::KEY_W-1:0] key;
  logic [krt_pkg::HDL_W-1:0] handle;

  modport source (output valid, output opcode, output key, output handle, input ready);
  modport sink   (input valid, input opcode, input key, input handle, output ready);
endinterface

interface krt_out_if;
  logic                            valid;
  logic                            ready;
  logic [krt_pkg::STATUS_W-1:0]    status;
  logic [krt_pkg::HDL_W-1:0]       found_handle;
  logic [krt_pkg::ENTRY_CNT_W-1:0] entry_count;

  modport source (output valid, output status, output found_handle, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_handle, input entry_count,
                  output ready);
endinterface

// ===== rtl/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/keyed_registration_table.sv =====
// ----------------------------------------------------------------------------
// keyed_registration_table - bounded unordered key/handle table
// Lookup, insert and remove by linear scan of one entry RAM with one shared
// key comparator; remove fills the hole with the last entry.
// ----------------------------------------------------------------------------
// Sequence, request beat to out_ch.valid: a miss or an accepted insert scans
//   every filled entry; a hit stops the scan at the matching entry, and a
//   remove that moves the last entry into the hole adds S_MOVE_RD and
//   S_MOVE_WR. Full-table insert and the unused opcode go straight to S_DONE.
// Throughput: one request at a time; in_ch.ready is high only while idle, so
//   the next beat lands in the cycle out_ch.valid rises at the earliest, later
//   while out_ch stalls. The scan reads one RAM entry per cycle, which sets
//   the rate.
// Reset: synchronous, active low; empties the table (fill count to zero).
//   Entry storage is not cleared, only entries below the fill count are read.
// ----------------------------------------------------------------------------
module keyed_registration_table (
  input  logic      clk,
  input  logic      rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,     // ready for a request beat
    S_SCAN,     // issue reads and compare keys, one entry per cycle
    S_MOVE_RD,  // read the last entry for hole fill
    S_MOVE_WR,  // write it into the freed slot
    S_DONE      // hand result to the output register
  } state_t;

  // Sequencer state
  state_t                     state_r,    state_nxt;
  krt_pkg::op_t               op_r,       op_nxt;
  logic [krt_pkg::KEY_W-1:0]  key_r,      key_nxt;
  logic [krt_pkg::HDL_W-1:0]  hdl_r,      hdl_nxt;
  logic [krt_pkg::CNT_W-1:0]  count_r,    count_nxt;
  logic [krt_pkg::CNT_W-1:0]  issue_r,    issue_nxt;   // next entry to read
  logic                       cmp_vld_r,  cmp_vld_nxt; // RAM data is live
  logic [krt_pkg::IDX_W-1:0]  cmp_idx_r,  cmp_idx_nxt; // entry under compare
  logic [krt_pkg::IDX_W-1:0]  slot_r,     slot_nxt;    // hole of a remove
  krt_pkg::status_t           res_st_r,   res_st_nxt;
  logic [krt_pkg::HDL_W-1:0]  res_hdl_r,  res_hdl_nxt;

  // Output register
  logic                            out_valid_r,  out_valid_nxt;
  logic [krt_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [krt_pkg::HDL_W-1:0]       out_hdl_r,    out_hdl_nxt;
  logic [krt_pkg::ENTRY_CNT_W-1:0] out_cnt_r,    out_cnt_nxt;

  // Entry RAM, {key, handle}
  logic                         ram_we;
  logic [krt_pkg::IDX_W-1:0]    ram_waddr;
  logic [krt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [krt_pkg::IDX_W-1:0]    ram_raddr;
  logic [krt_pkg::ENTRY_W-1:0]  ram_rdata;

  logic [krt_pkg::KEY_W-1:0]    rd_key;
  logic [krt_pkg::HDL_W-1:0]    rd_hdl;
  logic [krt_pkg::CNT_W-1:0]    last_idx;
  logic                         key_hit;
  logic                         scan_end;
  logic                         in_beat;

  krt_ram #(
    .WIDTH (krt_pkg::ENTRY_W),
    .DEPTH (krt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[krt_pkg::ENTRY_W-1:krt_pkg::HDL_W];
  assign rd_hdl   = ram_rdata[krt_pkg::HDL_W-1:0];
  assign last_idx = count_r - krt_pkg::CNT_W'(1);

  // The shared comparator: one key per cycle. Reads go out in index order,
  // so the first hit is the first match.
  assign key_hit  = cmp_vld_r && (rd_key == key_r);
  // Nothing left in flight and nothing left to issue: a miss.
  assign scan_end = !cmp_vld_r && (issue_r >= count_r);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_beat             = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.found_handle = out_hdl_r;
  assign out_ch.entry_count  = out_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hdl_nxt        = hdl_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    slot_nxt       = slot_r;
    res_st_nxt     = res_st_r;
    res_hdl_nxt    = res_hdl_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_hdl_nxt    = out_hdl_r;
    out_cnt_nxt    = out_cnt_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[krt_pkg::IDX_W-1:0];
    ram_wdata = {key_r, hdl_r};
    ram_raddr = issue_r[krt_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt      = krt_pkg::op_t'(in_ch.opcode);
          key_nxt     = in_ch.key;
          hdl_nxt     = in_ch.handle;
          issue_nxt   = '0;
          cmp_vld_nxt = 1'b0;
          res_st_nxt  = krt_pkg::ST_OK;
          res_hdl_nxt = '0;
          unique case (krt_pkg::op_t'(in_ch.opcode))
            krt_pkg::OP_INSERT: begin
              // full check wins over duplicate check
              if (count_r >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)) begin
                res_st_nxt = krt_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt  = S_SCAN;
              end
            end
            krt_pkg::OP_LOOKUP,
            krt_pkg::OP_REMOVE: state_nxt = S_SCAN;
            krt_pkg::OP_NOP:    state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        if (issue_r < count_r) begin
          issue_nxt   = issue_r + krt_pkg::CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[krt_pkg::IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end

        priority if (key_hit) begin
          unique case (op_r)
            krt_pkg::OP_LOOKUP: begin
              res_hdl_nxt = rd_hdl;
              state_nxt   = S_DONE;
            end
            krt_pkg::OP_INSERT: begin
              res_st_nxt = krt_pkg::ST_DUP;
              state_nxt  = S_DONE;
            end
            krt_pkg::OP_REMOVE: begin
              res_hdl_nxt = rd_hdl;
              if (krt_pkg::CNT_W'(cmp_idx_r) == last_idx) begin
                count_nxt = last_idx;   // last entry just drops off
                state_nxt = S_DONE;
              end else begin
                slot_nxt  = cmp_idx_r;
                state_nxt = S_MOVE_RD;
              end
            end
            krt_pkg::OP_NOP: state_nxt = S_DONE;
          endcase
        end else if (scan_end) begin
          if (op_r == krt_pkg::OP_INSERT) begin
            ram_we    = 1'b1;           // append at the fill count
            count_nxt = count_r + krt_pkg::CNT_W'(1);
          end else begin
            res_st_nxt = krt_pkg::ST_MISSING;
          end
          state_nxt = S_DONE;
        end else begin
          // keep scanning
        end
      end

      S_MOVE_RD: begin
        ram_raddr = last_idx[krt_pkg::IDX_W-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata;
        count_nxt = last_idx;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_hdl_nxt    = res_hdl_r;
          out_cnt_nxt    = krt_pkg::ENTRY_CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload, no reset needed
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hdl_r        <= hdl_nxt;
    issue_r      <= issue_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    slot_r       <= slot_nxt;
    res_st_r     <= res_st_nxt;
    res_hdl_r    <= res_hdl_nxt;
    out_status_r <= out_status_nxt;
    out_hdl_r    <= out_hdl_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

endmodule

// ===== rtl/krt_chk.sv =====
// ----------------------------------------------------------------------------
// krt_chk - port-level checks for the keyed registration table
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module krt_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [krt_pkg::STATUS_W-1:0]    out_status,
  input logic [krt_pkg::HDL_W-1:0]       out_found_handle,
  input logic [krt_pkg::ENTRY_CNT_W-1:0] out_entry_count
);

  // One request in flight: the block stops taking beats after one lands.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // A failed operation carries no handle.
  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != krt_pkg::ST_OK)) |-> (out_found_handle == '0))
    else $error("handle reported on failed operation");

  // Fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_entry_count) <= krt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A stalled response beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_found_handle)
       && $stable(out_entry_count)))
    else $error("response changed while stalled");

endmodule

bind keyed_registration_table krt_chk u_krt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_found_handle (out_ch.found_handle),
  .out_entry_count  (out_ch.entry_count)
);
